>>> hdl/tsps_pkg.sv
package tsps_pkg;

    localparam int NUM_CELLS = 2;
    localparam int TEMP_MIN  = 0;
    localparam int TEMP_MAX  = 1100;

    localparam int CELL_W = 1;
    localparam int TEMP_W = 16;
    localparam int SEC_W  = 15;
    localparam int REQ_W  = 3;
    localparam int ERR_W  = 2;
    localparam int CIDX_W = 3;

    localparam int RATE_SCALE  = 1000;
    localparam int RATE_PERIOD = 60000;
    localparam int STEP_DIV    = RATE_PERIOD / RATE_SCALE;
    localparam int STEP_MAX    = (1 << (TEMP_W - 1)) / STEP_DIV;
    localparam int STEP_W      = $clog2(STEP_MAX + 1);
    localparam int RECIP_SH    = 22;
    localparam int RECIP_M     = ((1 << RECIP_SH) + STEP_DIV - 1) / STEP_DIV;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic        [SEC_W-1:0]  t_secs;
    typedef logic        [CELL_W-1:0] t_cell;
    typedef logic        [REQ_W-1:0]  t_req;
    typedef logic        [ERR_W-1:0]  t_err;
    typedef logic        [CIDX_W-1:0] t_cfg_idx;
    typedef logic        [STEP_W-1:0] t_step;
    typedef logic        [1:0]        t_run;
    typedef logic        [2:0]        t_pcode;

    localparam t_req REQ_TICK       = 3'd0;
    localparam t_req REQ_START_JUMP = 3'd1;
    localparam t_req REQ_START_PROG = 3'd2;
    localparam t_req REQ_STOP       = 3'd3;
    localparam t_req REQ_MEASURED   = 3'd4;
    localparam t_req REQ_ERROR      = 3'd5;

    localparam t_err ERR_NONE   = 2'd0;
    localparam t_err ERR_SENSOR = 2'd3;

    localparam t_cfg_idx CFG_JUMP_RATE  = 3'd0;
    localparam t_cfg_idx CFG_START_TEMP = 3'd1;
    localparam t_cfg_idx CFG_START_HOLD = 3'd2;
    localparam t_cfg_idx CFG_RAMP_RATE  = 3'd3;
    localparam t_cfg_idx CFG_NEXT_TEMP  = 3'd4;
    localparam t_cfg_idx CFG_WAIT       = 3'd5;
    localparam t_cfg_idx CFG_REPEATS    = 3'd6;

    localparam t_temp RST_JUMP_RATE  = 16'sd50;
    localparam t_temp RST_START_TEMP = 16'sd250;
    localparam t_secs RST_START_HOLD = 15'd300;
    localparam t_temp RST_RAMP_RATE  = 16'sd10;
    localparam t_temp RST_NEXT_TEMP  = 16'sd110;
    localparam t_secs RST_WAIT       = 15'd30;
    localparam t_secs RST_REPEATS    = 15'd79;
    localparam t_temp RST_CELL_TEMP  = 16'sd250;

    localparam t_run RUN_STOP = 2'd0;
    localparam t_run RUN_JUMP = 2'd1;
    localparam t_run RUN_PROG = 2'd2;

    localparam t_pcode PC_IDLE     = 3'd0;
    localparam t_pcode PC_TO_START = 3'd1;
    localparam t_pcode PC_HOLD     = 3'd2;
    localparam t_pcode PC_RAMP     = 3'd3;
    localparam t_pcode PC_WAIT     = 3'd4;
    localparam t_pcode PC_DONE     = 3'd5;

    typedef enum logic [2:0] {
        MD_STOP = 3'b001,
        MD_JUMP = 3'b010,
        MD_PROG = 3'b100
    } t_mode;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_TO_START = 6'b000010,
        PH_HOLD     = 6'b000100,
        PH_RAMP     = 6'b001000,
        PH_WAIT     = 6'b010000,
        PH_DONE     = 6'b100000
    } t_phase;

    typedef struct packed {
        logic  zero;
        t_step step;
    } t_rate;

    typedef struct packed {
        t_rate jump;
        t_temp base_temp;
        t_secs base_hold;
        t_rate ramp;
        t_temp first_step;
        t_secs wait_s;
        t_secs repeats;
    } t_cfg;

    function automatic t_run mode_code(t_mode m);
        t_run code;
        unique case (m)
            MD_JUMP: code = RUN_JUMP;
            MD_PROG: code = RUN_PROG;
            default: code = RUN_STOP;
        endcase
        return code;
    endfunction

    function automatic t_pcode phase_code(t_phase p);
        t_pcode code;
        unique case (p)
            PH_TO_START: code = PC_TO_START;
            PH_HOLD:     code = PC_HOLD;
            PH_RAMP:     code = PC_RAMP;
            PH_WAIT:     code = PC_WAIT;
            PH_DONE:     code = PC_DONE;
            default:     code = PC_IDLE;
        endcase
        return code;
    endfunction

    // per-tick step: max(1, |rate| / 60) by reciprocal multiply
    function automatic t_rate rate_step(t_temp rate);
        logic signed [TEMP_W:0] wide;
        logic        [TEMP_W:0] mag;
        logic        [31:0]     prod;
        t_step                  q;
        t_rate                  res;
        wide = (TEMP_W+1)'(rate);
        mag  = unsigned'(wide[TEMP_W] ? -wide : wide);
        prod = 32'(mag) * 32'(RECIP_M);
        q    = prod[RECIP_SH +: STEP_W];
        res.zero = (mag == '0);
        res.step = (q == '0) ? t_step'(1) : q;
        return res;
    endfunction

    function automatic t_temp move_toward(t_temp cur, t_temp tgt, t_rate rate);
        logic signed [TEMP_W+1:0] diff;
        logic signed [TEMP_W+1:0] stp;
        t_temp                    res;
        diff = (TEMP_W+2)'(tgt) - (TEMP_W+2)'(cur);
        stp  = signed'((TEMP_W+2)'(rate.step));
        if (rate.zero || diff == '0) begin
            res = tgt;
        end else if (diff > 0) begin
            res = (diff <= stp) ? tgt : TEMP_W'((TEMP_W+2)'(cur) + stp);
        end else begin
            res = (-diff <= stp) ? tgt : TEMP_W'((TEMP_W+2)'(cur) - stp);
        end
        return res;
    endfunction

    function automatic t_temp clamp_step(t_temp a, t_temp b);
        logic signed [TEMP_W:0] sum;
        sum = (TEMP_W+1)'(a) + (TEMP_W+1)'(b);
        if (sum < TEMP_MIN) begin
            sum = (TEMP_W+1)'(TEMP_MIN);
        end
        if (sum > TEMP_MAX) begin
            sum = (TEMP_W+1)'(TEMP_MAX);
        end
        return TEMP_W'(sum);
    endfunction

endpackage

>>> hdl/tsps_if.sv
interface tsps_in_if;
    logic              valid;
    logic              ready;
    tsps_pkg::t_req    req_type;
    tsps_pkg::t_cell   cell_sel;
    tsps_pkg::t_temp   value;

    modport source (output valid, output req_type, output cell_sel, output value, input ready);
    modport sink   (input valid, input req_type, input cell_sel, input value, output ready);
endinterface

interface tsps_out_if;
    logic              valid;
    logic              ready;
    tsps_pkg::t_cell   cell_out;
    tsps_pkg::t_temp   setpoint;
    tsps_pkg::t_run    run_state;
    tsps_pkg::t_pcode  prog_phase;
    tsps_pkg::t_err    error_code;
    logic              start_refused;

    modport source (
        output valid, output cell_out, output setpoint, output run_state,
        output prog_phase, output error_code, output start_refused, input ready
    );
    modport sink (
        input valid, input cell_out, input setpoint, input run_state,
        input prog_phase, input error_code, input start_refused, output ready
    );
endinterface

>>> hdl/tsps_cfg.sv
module tsps_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  tsps_pkg::t_cfg_idx i_idx,
    input  tsps_pkg::t_temp    i_wdata,
    output tsps_pkg::t_cfg     o_cfg
);
    import tsps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jump       <= rate_step(RST_JUMP_RATE);
            r_cfg.base_temp  <= RST_START_TEMP;
            r_cfg.base_hold  <= RST_START_HOLD;
            r_cfg.ramp       <= rate_step(RST_RAMP_RATE);
            r_cfg.first_step <= RST_NEXT_TEMP;
            r_cfg.wait_s     <= RST_WAIT;
            r_cfg.repeats    <= RST_REPEATS;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_JUMP_RATE:  r_cfg.jump       <= rate_step(i_wdata);
                CFG_START_TEMP: r_cfg.base_temp  <= i_wdata;
                CFG_START_HOLD: r_cfg.base_hold  <= i_wdata[SEC_W-1:0];
                CFG_RAMP_RATE:  r_cfg.ramp       <= rate_step(i_wdata);
                CFG_NEXT_TEMP:  r_cfg.first_step <= i_wdata;
                CFG_WAIT:       r_cfg.wait_s     <= i_wdata[SEC_W-1:0];
                CFG_REPEATS:    r_cfg.repeats    <= i_wdata[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/tsps_engine.sv
module tsps_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsps_pkg::t_cfg  i_cfg,
    tsps_in_if.sink         i_req,
    tsps_out_if.source      o_rsp
);
    import tsps_pkg::*;

    logic   r_s1_valid;
    t_req   r_s1_req;
    t_cell  r_s1_cell;
    t_temp  r_s1_value;
    logic   s1_fire;
    logic   cell_ok;

    t_mode  r_mode  [NUM_CELLS];
    t_phase r_phase [NUM_CELLS];
    t_temp  r_cmd   [NUM_CELLS];
    t_temp  r_meas  [NUM_CELLS];
    t_temp  r_tgt   [NUM_CELLS];
    t_temp  r_stgt  [NUM_CELLS];
    t_temp  r_ssize [NUM_CELLS];
    t_secs  r_secs  [NUM_CELLS];
    t_secs  r_steps [NUM_CELLS];
    t_err   r_fault [NUM_CELLS];

    t_mode  cur_mode;
    t_phase cur_phase;
    t_temp  cur_cmd;
    t_secs  cur_secs;
    t_secs  cur_steps;
    t_temp  cur_stgt;
    t_err   cur_fault;

    t_mode  n_mode;
    t_phase n_phase;
    t_temp  n_cmd;
    t_temp  n_meas;
    t_temp  n_tgt;
    t_temp  n_stgt;
    t_temp  n_ssize;
    t_secs  n_secs;
    t_secs  n_steps;
    t_err   n_fault;
    logic   n_refused;

    t_temp  mv_tgt;
    t_rate  mv_rate;
    t_temp  mv_out;

    logic   r_o_valid;
    t_cell  r_o_cell;
    t_temp  r_o_cmd;
    t_run   r_o_run;
    t_pcode r_o_phase;
    t_err   r_o_fault;
    logic   r_o_refused;

    assign s1_fire     = r_s1_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign cell_ok     = int'(r_s1_cell) < NUM_CELLS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_req   <= i_req.req_type;
            r_s1_cell  <= i_req.cell_sel;
            r_s1_value <= i_req.value;
        end
    end

    assign cur_mode  = r_mode[r_s1_cell];
    assign cur_phase = r_phase[r_s1_cell];
    assign cur_cmd   = r_cmd[r_s1_cell];
    assign cur_secs  = r_secs[r_s1_cell];
    assign cur_steps = r_steps[r_s1_cell];
    assign cur_stgt  = r_stgt[r_s1_cell];
    assign cur_fault = r_fault[r_s1_cell];

    always_comb begin
        mv_tgt  = r_tgt[r_s1_cell];
        mv_rate = i_cfg.jump;
        if (cur_mode == MD_PROG) begin
            if (cur_phase == PH_RAMP) begin
                mv_tgt  = cur_stgt;
                mv_rate = i_cfg.ramp;
            end else begin
                mv_tgt = i_cfg.base_temp;
            end
        end
    end

    assign mv_out = move_toward(cur_cmd, mv_tgt, mv_rate);

    always_comb begin
        n_mode    = cur_mode;
        n_phase   = cur_phase;
        n_cmd     = cur_cmd;
        n_meas    = r_meas[r_s1_cell];
        n_tgt     = r_tgt[r_s1_cell];
        n_stgt    = cur_stgt;
        n_ssize   = r_ssize[r_s1_cell];
        n_secs    = cur_secs;
        n_steps   = cur_steps;
        n_fault   = cur_fault;
        n_refused = 1'b0;
        unique case (r_s1_req)
            REQ_TICK: begin
                unique case (cur_mode)
                    MD_JUMP: n_cmd = mv_out;
                    MD_PROG: begin
                        unique case (cur_phase)
                            PH_TO_START: begin
                                n_cmd = mv_out;
                                if (mv_out == i_cfg.base_temp) begin
                                    n_phase = PH_HOLD;
                                    n_secs  = '0;
                                end
                            end
                            PH_HOLD: begin
                                n_cmd = i_cfg.base_temp;
                                if (cur_secs >= i_cfg.base_hold) begin
                                    n_phase = PH_RAMP;
                                    n_secs  = '0;
                                    n_stgt  = i_cfg.first_step;
                                end else begin
                                    n_secs = cur_secs + 1'b1;
                                end
                            end
                            PH_RAMP: begin
                                n_cmd = mv_out;
                                if (mv_out == cur_stgt) begin
                                    n_phase = PH_WAIT;
                                    n_secs  = '0;
                                end
                            end
                            PH_WAIT: begin
                                n_cmd = cur_stgt;
                                if (cur_secs >= i_cfg.wait_s) begin
                                    n_secs = '0;
                                    if (cur_steps >= i_cfg.repeats) begin
                                        n_phase = PH_DONE;
                                    end else begin
                                        n_steps = cur_steps + 1'b1;
                                        n_stgt  = clamp_step(cur_stgt, r_ssize[r_s1_cell]);
                                        n_phase = PH_RAMP;
                                    end
                                end else begin
                                    n_secs = cur_secs + 1'b1;
                                end
                            end
                            PH_DONE: n_cmd = cur_stgt;
                            default: n_phase = PH_TO_START;
                        endcase
                    end
                    default: ;
                endcase
            end
            REQ_START_JUMP: begin
                if (cur_fault != ERR_NONE) begin
                    n_refused = 1'b1;
                end else begin
                    n_mode  = MD_JUMP;
                    n_phase = PH_IDLE;
                    n_secs  = '0;
                    n_steps = '0;
                    n_tgt   = r_s1_value;
                    n_cmd   = r_meas[r_s1_cell];
                end
            end
            REQ_START_PROG: begin
                if (cur_fault != ERR_NONE) begin
                    n_refused = 1'b1;
                end else begin
                    n_mode  = MD_PROG;
                    n_phase = PH_TO_START;
                    n_secs  = '0;
                    n_steps = '0;
                    n_ssize = t_temp'(i_cfg.first_step - i_cfg.base_temp);
                    n_stgt  = i_cfg.base_temp;
                    n_cmd   = r_meas[r_s1_cell];
                end
            end
            REQ_STOP: begin
                n_mode  = MD_STOP;
                n_phase = PH_IDLE;
                n_secs  = '0;
                n_steps = '0;
            end
            REQ_MEASURED: begin
                n_meas = r_s1_value;
                if (cur_fault == ERR_SENSOR) begin
                    n_fault = ERR_NONE;
                end
            end
            REQ_ERROR: begin
                if (r_s1_value[TEMP_W-1:ERR_W] == '0) begin
                    n_fault = r_s1_value[ERR_W-1:0];
                    if (r_s1_value[ERR_W-1:0] != ERR_NONE) begin
                        n_mode  = MD_STOP;
                        n_phase = PH_IDLE;
                        n_secs  = '0;
                        n_steps = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CELLS; i++) begin
                r_mode[i]  <= MD_STOP;
                r_phase[i] <= PH_IDLE;
                r_cmd[i]   <= RST_CELL_TEMP;
                r_meas[i]  <= RST_CELL_TEMP;
                r_tgt[i]   <= RST_CELL_TEMP;
                r_stgt[i]  <= '0;
                r_ssize[i] <= '0;
                r_secs[i]  <= '0;
                r_steps[i] <= '0;
                r_fault[i] <= ERR_NONE;
            end
        end else if (s1_fire && cell_ok) begin
            r_mode[r_s1_cell]  <= n_mode;
            r_phase[r_s1_cell] <= n_phase;
            r_cmd[r_s1_cell]   <= n_cmd;
            r_meas[r_s1_cell]  <= n_meas;
            r_tgt[r_s1_cell]   <= n_tgt;
            r_stgt[r_s1_cell]  <= n_stgt;
            r_ssize[r_s1_cell] <= n_ssize;
            r_secs[r_s1_cell]  <= n_secs;
            r_steps[r_s1_cell] <= n_steps;
            r_fault[r_s1_cell] <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_fire) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_o_cell <= r_s1_cell;
            if (cell_ok) begin
                r_o_cmd     <= n_cmd;
                r_o_run     <= mode_code(n_mode);
                r_o_phase   <= phase_code(n_phase);
                r_o_fault   <= n_fault;
                r_o_refused <= n_refused;
            end else begin
                r_o_cmd     <= '0;
                r_o_run     <= RUN_STOP;
                r_o_phase   <= PC_IDLE;
                r_o_fault   <= ERR_NONE;
                r_o_refused <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.cell_out      = r_o_cell;
    assign o_rsp.setpoint      = r_o_cmd;
    assign o_rsp.run_state     = r_o_run;
    assign o_rsp.prog_phase    = r_o_phase;
    assign o_rsp.error_code    = r_o_fault;
    assign o_rsp.start_refused = r_o_refused;

endmodule

>>> hdl/temperature_setpoint_program_sequencer.sv
// Flow: a beat taken into the input register moves into the result register
// unless a stalled result still occupies it.
// Throughput: one beat per cycle while the result is not stalled; each beat reads
// and writes its cell's state in a single pass between input and result registers.
// Reset: synchronous, active low; every cell stops at setpoint 250 with no fault,
// and the program registers return to their defaults.
module temperature_setpoint_program_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tsps_in_if.sink            i_req,
    tsps_out_if.source         o_rsp,
    input  logic               i_cfg_we,
    input  tsps_pkg::t_cfg_idx i_cfg_idx,
    input  tsps_pkg::t_temp    i_cfg_wdata
);
    import tsps_pkg::*;

    t_cfg cfg;

    tsps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    tsps_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

>>> tb/tb_top.sv
module tb_top;
    import tsps_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;

    localparam t_req  REQ_SPARE_6  = 3'd6;
    localparam t_req  REQ_SPARE_7  = 3'd7;
    localparam t_err  ERR_WATER    = 2'd1;
    localparam t_err  ERR_PELTIER  = 2'd2;
    localparam t_temp ERR_CODE_BAD = 16'sd4;

    typedef struct {
        t_run        mode;
        t_pcode      phase;
        t_temp       cmd;
        t_temp       measured;
        t_temp       target;
        t_temp       step_tgt;
        t_temp       step_size;
        int unsigned secs;
        int unsigned steps;
        t_err        fault;
    } t_cell_state;

    typedef struct {
        t_cell  cell_idx;
        t_temp  cmd;
        t_run   run;
        t_pcode phase;
        t_err   fault;
        logic   refused;
    } t_cell_status;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_cfg_we    = 1'b0;
    t_cfg_idx i_cfg_idx   = CFG_JUMP_RATE;
    t_temp    i_cfg_wdata = '0;

    tsps_in_if  req_if ();
    tsps_out_if rsp_if ();

    temperature_setpoint_program_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    t_cell_state  cell_st [NUM_CELLS];
    t_temp        cfg_jump_rate;
    t_temp        cfg_base_temp;
    t_secs        cfg_base_hold;
    t_temp        cfg_ramp_rate;
    t_temp        cfg_first_step;
    t_secs        cfg_wait;
    t_secs        cfg_repeats;

    t_cell_status status_due_q [$];
    int           fail_count     = 0;
    int           beats_sent     = 0;
    int           settings_count = 0;
    int           refusals_seen  = 0;
    int           done_seen      = 0;
    int           burst_left     = 0;
    int           quiet_cycles   = 0;
    bit           gaps_off         = 1'b0;
    bit           hold_off_pending = 1'b0;

    function automatic t_temp ramp_toward(t_temp cur, t_temp tgt, t_temp rate);
        int mag;
        int diff;
        int stp;
        mag = (rate < 0) ? -int'(rate) : int'(rate);
        if (mag == 0) begin
            return tgt;
        end
        diff = int'(tgt) - int'(cur);
        if (diff == 0) begin
            return tgt;
        end
        stp = mag * RATE_SCALE / RATE_PERIOD;
        if (stp < 1) begin
            stp = 1;
        end
        if (diff > 0) begin
            return (diff <= stp) ? tgt : t_temp'(int'(cur) + stp);
        end
        return (-diff <= stp) ? tgt : t_temp'(int'(cur) - stp);
    endfunction

    function automatic void halt_cell(t_cell c);
        cell_st[c].mode  = RUN_STOP;
        cell_st[c].phase = PC_IDLE;
        cell_st[c].secs  = 0;
        cell_st[c].steps = 0;
    endfunction

    function automatic void advance_program(t_cell c);
        int sum;
        case (cell_st[c].phase)
            PC_TO_START: begin
                cell_st[c].cmd = ramp_toward(cell_st[c].cmd, cfg_base_temp, cfg_jump_rate);
                if (cell_st[c].cmd == cfg_base_temp) begin
                    cell_st[c].phase = PC_HOLD;
                    cell_st[c].secs  = 0;
                end
            end
            PC_HOLD: begin
                cell_st[c].cmd = cfg_base_temp;
                if (cell_st[c].secs >= cfg_base_hold) begin
                    cell_st[c].phase    = PC_RAMP;
                    cell_st[c].secs     = 0;
                    cell_st[c].step_tgt = cfg_first_step;
                end else begin
                    cell_st[c].secs++;
                end
            end
            PC_RAMP: begin
                cell_st[c].cmd = ramp_toward(cell_st[c].cmd, cell_st[c].step_tgt,
                                             cfg_ramp_rate);
                if (cell_st[c].cmd == cell_st[c].step_tgt) begin
                    cell_st[c].phase = PC_WAIT;
                    cell_st[c].secs  = 0;
                end
            end
            PC_WAIT: begin
                cell_st[c].cmd = cell_st[c].step_tgt;
                if (cell_st[c].secs >= cfg_wait) begin
                    cell_st[c].secs = 0;
                    if (cell_st[c].steps >= cfg_repeats) begin
                        cell_st[c].phase = PC_DONE;
                    end else begin
                        cell_st[c].steps++;
                        sum = int'(cell_st[c].step_tgt) + int'(cell_st[c].step_size);
                        if (sum < TEMP_MIN) begin
                            sum = TEMP_MIN;
                        end
                        if (sum > TEMP_MAX) begin
                            sum = TEMP_MAX;
                        end
                        cell_st[c].step_tgt = t_temp'(sum);
                        cell_st[c].phase    = PC_RAMP;
                    end
                end else begin
                    cell_st[c].secs++;
                end
            end
            PC_DONE: begin
                cell_st[c].cmd = cell_st[c].step_tgt;
            end
            default: begin
                cell_st[c].phase = PC_TO_START;
            end
        endcase
    endfunction

    function automatic t_cell_status next_cell_status(t_req rq, t_cell c, t_temp v);
        t_cell_status st;
        logic         refused;
        refused = 1'b0;
        case (rq)
            REQ_TICK: begin
                if (cell_st[c].mode == RUN_JUMP) begin
                    cell_st[c].cmd = ramp_toward(cell_st[c].cmd, cell_st[c].target,
                                                 cfg_jump_rate);
                end else if (cell_st[c].mode == RUN_PROG) begin
                    advance_program(c);
                end
            end
            REQ_START_JUMP: begin
                if (cell_st[c].fault != ERR_NONE) begin
                    refused = 1'b1;
                end else begin
                    cell_st[c].mode   = RUN_JUMP;
                    cell_st[c].phase  = PC_IDLE;
                    cell_st[c].secs   = 0;
                    cell_st[c].steps  = 0;
                    cell_st[c].target = v;
                    cell_st[c].cmd    = cell_st[c].measured;
                end
            end
            REQ_START_PROG: begin
                if (cell_st[c].fault != ERR_NONE) begin
                    refused = 1'b1;
                end else begin
                    cell_st[c].mode      = RUN_PROG;
                    cell_st[c].phase     = PC_TO_START;
                    cell_st[c].secs      = 0;
                    cell_st[c].steps     = 0;
                    cell_st[c].step_size = t_temp'(int'(cfg_first_step) - int'(cfg_base_temp));
                    cell_st[c].step_tgt  = cfg_base_temp;
                    cell_st[c].cmd       = cell_st[c].measured;
                end
            end
            REQ_STOP: begin
                halt_cell(c);
            end
            REQ_MEASURED: begin
                cell_st[c].measured = v;
                if (cell_st[c].fault == ERR_SENSOR) begin
                    cell_st[c].fault = ERR_NONE;
                end
            end
            REQ_ERROR: begin
                if (int'(v) >= int'(ERR_NONE) && int'(v) <= int'(ERR_SENSOR)) begin
                    cell_st[c].fault = t_err'(v);
                    if (cell_st[c].fault != ERR_NONE) begin
                        halt_cell(c);
                    end
                end
            end
            default: ;
        endcase
        st.cell_idx = c;
        st.cmd      = cell_st[c].cmd;
        st.run      = cell_st[c].mode;
        st.phase    = cell_st[c].phase;
        st.fault    = cell_st[c].fault;
        st.refused  = refused;
        return st;
    endfunction

    function automatic void reset_cells();
        cfg_jump_rate  = RST_JUMP_RATE;
        cfg_base_temp  = RST_START_TEMP;
        cfg_base_hold  = RST_START_HOLD;
        cfg_ramp_rate  = RST_RAMP_RATE;
        cfg_first_step = RST_NEXT_TEMP;
        cfg_wait       = RST_WAIT;
        cfg_repeats    = RST_REPEATS;
        for (int c = 0; c < NUM_CELLS; c++) begin
            cell_st[c].mode      = RUN_STOP;
            cell_st[c].phase     = PC_IDLE;
            cell_st[c].cmd       = RST_CELL_TEMP;
            cell_st[c].measured  = RST_CELL_TEMP;
            cell_st[c].target    = RST_CELL_TEMP;
            cell_st[c].step_tgt  = '0;
            cell_st[c].step_size = '0;
            cell_st[c].secs      = 0;
            cell_st[c].steps     = 0;
            cell_st[c].fault     = ERR_NONE;
        end
    endfunction

    function automatic t_temp near_temp();
        if ($urandom_range(0, 4) == 0) begin
            return t_temp'($urandom());
        end
        return t_temp'(int'($urandom_range(0, 1400)) - 100);
    endfunction

    task automatic send_beat(t_req rq, t_cell c, t_temp v);
        int gap;
        t_cell_status st;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gaps_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid    <= 1'b1;
        req_if.req_type <= rq;
        req_if.cell_sel <= c;
        req_if.value    <= v;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        st = next_cell_status(rq, c, v);
        status_due_q.push_back(st);
        beats_sent++;
        if (st.refused) begin
            refusals_seen++;
        end
        if (st.phase == PC_DONE) begin
            done_seen++;
        end
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (status_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_temp data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(t_temp jr, t_temp st, t_temp hold, t_temp rr,
                                 t_temp nt, t_temp wt, t_temp rep);
        wait_idle();
        write_reg(CFG_JUMP_RATE, jr);
        write_reg(CFG_START_TEMP, st);
        write_reg(CFG_START_HOLD, hold);
        write_reg(CFG_RAMP_RATE, rr);
        write_reg(CFG_NEXT_TEMP, nt);
        write_reg(CFG_WAIT, wt);
        write_reg(CFG_REPEATS, rep);
        i_cfg_we <= 1'b0;
        cfg_jump_rate  = jr;
        cfg_base_temp  = st;
        cfg_base_hold  = hold[SEC_W-1:0];
        cfg_ramp_rate  = rr;
        cfg_first_step = nt;
        cfg_wait       = wt[SEC_W-1:0];
        cfg_repeats    = rep[SEC_W-1:0];
        settings_count++;
    endtask

    task automatic program_run(t_cell c, t_temp start_meas, int ticks);
        send_beat(REQ_ERROR, c, t_temp'(ERR_NONE));
        send_beat(REQ_MEASURED, c, start_meas);
        send_beat(REQ_START_PROG, c, t_temp'($urandom()));
        repeat (ticks) send_beat(REQ_TICK, c, t_temp'($urandom()));
    endtask

    // mostly well-formed start-then-tick runs, with some noise and broken runs
    task automatic run_sequences(int beats);
        int    stop_at;
        int    roll;
        t_cell c;
        t_req  kind;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            c = t_cell'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 6) begin
                send_beat(REQ_ERROR, c, t_temp'(ERR_NONE));
            end
            if ($urandom_range(0, 9) < 7) begin
                send_beat(REQ_MEASURED, c, near_temp());
            end
            kind = ($urandom_range(0, 9) < 6) ? REQ_START_PROG : REQ_START_JUMP;
            send_beat(kind, c, near_temp());
            repeat ($urandom_range(5, 150)) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    send_beat(t_req'($urandom_range(0, 7)), t_cell'($urandom_range(0, 1)),
                              t_temp'($urandom()));
                end else if (roll < 6) begin
                    case ($urandom_range(0, 3))
                        0: send_beat(REQ_STOP, c, t_temp'($urandom()));
                        1: send_beat(REQ_ERROR, c, t_temp'($urandom_range(1, 3)));
                        2: send_beat(REQ_START_JUMP, c, near_temp());
                        default: send_beat(REQ_START_PROG, c, near_temp());
                    endcase
                end else begin
                    send_beat(REQ_TICK, ($urandom_range(0, 3) == 0) ? t_cell'(~c) : c,
                              t_temp'($urandom()));
                end
            end
        end
    endtask

    task automatic test_directed();
        send_beat(REQ_TICK, 1'b0, 16'sh7FFF);
        send_beat(REQ_MEASURED, 1'b0, -16'sd32768);
        send_beat(REQ_MEASURED, 1'b1, 16'sd32767);
        send_beat(REQ_START_JUMP, 1'b0, 16'sd32767);
        send_beat(REQ_TICK, 1'b0, '0);
        send_beat(REQ_START_JUMP, 1'b1, -16'sd32768);
        send_beat(REQ_TICK, 1'b1, '0);
        send_beat(REQ_SPARE_6, 1'b0, '0);
        send_beat(REQ_SPARE_7, 1'b1, -16'sd1);
        send_beat(REQ_ERROR, 1'b0, t_temp'(ERR_SENSOR));
        send_beat(REQ_START_JUMP, 1'b0, 16'sd100);
        send_beat(REQ_START_PROG, 1'b0, '0);
        send_beat(REQ_MEASURED, 1'b0, 16'sd250);
        send_beat(REQ_ERROR, 1'b0, t_temp'(ERR_WATER));
        send_beat(REQ_MEASURED, 1'b0, 16'sd240);
        send_beat(REQ_ERROR, 1'b0, ERR_CODE_BAD);
        send_beat(REQ_ERROR, 1'b0, -16'sd1);
        send_beat(REQ_ERROR, 1'b0, t_temp'(ERR_PELTIER));
        send_beat(REQ_ERROR, 1'b0, t_temp'(ERR_NONE));
        send_beat(REQ_START_PROG, 1'b0, '0);
        send_beat(REQ_TICK, 1'b0, '0);
        send_beat(REQ_START_JUMP, 1'b1, 16'sd500);
        send_beat(REQ_ERROR, 1'b1, t_temp'(ERR_NONE));
        send_beat(REQ_STOP, 1'b1, '0);
        send_beat(REQ_TICK, 1'b1, '0);
    endtask

    task automatic test_jump_rates();
        t_temp rates [5];
        rates = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd59, -16'sd60};
        foreach (rates[i]) begin
            load_settings(rates[i], 16'sd300, 16'sd2, 16'sd600, 16'sd360, 16'sd1, 16'sd2);
            run_sequences(60);
        end
    endtask

    task automatic test_step_clamp();
        load_settings(16'sd32767, 16'sd900, 16'sd1, -16'sd32768, 16'sd1050, 16'sd0, 16'sd3);
        program_run(1'b0, 16'sd900, 40);
        load_settings(16'sd32767, 16'sd200, 16'sd1, -16'sd32768, -16'sd40, 16'sd0, 16'sd3);
        program_run(1'b1, 16'sd200, 40);
        load_settings(16'sd32767, 16'sd0, 16'sd1, -16'sd32768, 16'sd32767, 16'sd0, 16'sd3);
        program_run(1'b0, 16'sd0, 150);
        load_settings(16'sd32767, -16'sd32768, 16'sd1, -16'sd32768, 16'sd32767, 16'sd0,
                      16'sd3);
        program_run(1'b1, -16'sd32768, 200);
    endtask

    task automatic test_long_counts();
        load_settings(16'sd1, 16'sd260, 16'shFFFF, 16'sd1, 16'sd300, 16'sh7FFF, 16'shFFFF);
        program_run(1'b1, 16'sd250, 30);
        program_run(1'b0, 16'sd255, 10);
    endtask

    task automatic test_backpressure();
        load_settings(16'sd3000, 16'sd400, 16'sd1, 16'sd1200, 16'sd450, 16'sd1, 16'sd3);
        gaps_off         = 1'b1;
        hold_off_pending = 1'b1;
        run_sequences(80);
        gaps_off = 1'b0;
    endtask

    task automatic test_random_settings();
        int    mag;
        t_temp jr;
        t_temp st;
        t_temp rr;
        t_temp nt;
        repeat (5) begin
            mag = $urandom_range(600, 32767);
            case ($urandom_range(0, 3))
                0, 1: jr = $urandom_range(0, 1) ? t_temp'(-mag) : t_temp'(mag);
                2: jr = t_temp'(int'($urandom_range(0, 118)) - 59);
                default: jr = t_temp'($urandom());
            endcase
            st = ($urandom_range(0, 6) == 0) ? t_temp'($urandom())
                                             : t_temp'(int'($urandom_range(0, 1300)) - 100);
            nt = ($urandom_range(0, 6) == 0) ? t_temp'($urandom())
                 : t_temp'(int'(st) + int'($urandom_range(0, 600)) - 300);
            mag = $urandom_range(1200, 12000);
            if ($urandom_range(0, 3) == 0) begin
                rr = t_temp'($urandom());
            end else begin
                rr = $urandom_range(0, 1) ? t_temp'(-mag) : t_temp'(mag);
            end
            load_settings(jr, st,
                          t_temp'({1'($urandom_range(0, 1)), 15'($urandom_range(0, 4))}),
                          rr, nt,
                          t_temp'({1'($urandom_range(0, 1)), 15'($urandom_range(0, 4))}),
                          t_temp'({1'($urandom_range(0, 1)), 15'($urandom_range(0, 8))}));
            run_sequences(40);
        end
    endtask

    initial begin
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_TICK;
        req_if.cell_sel <= '0;
        req_if.value    <= '0;
        reset_cells();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_jump_rates();
        test_step_clamp();
        test_long_counts();
        test_backpressure();
        test_random_settings();
        wait_idle();
        $display("%0d request beats checked over %0d register settings", beats_sent,
                 settings_count);
        $display("%0d refused starts, %0d results in the finished program phase, %0d errors",
                 refusals_seen, done_seen, fail_count);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : rsp_stall
        int seg_left;
        int stall_pct;
        seg_left  = 0;
        stall_pct = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if (seg_left == 0) begin
                seg_left  = $urandom_range(1, 40);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
            end
            seg_left--;
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_cell_status want;
        if (rsp_if.valid && rsp_if.ready) begin
            if (status_due_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, cell %0d setpoint %0d",
                         $time, rsp_if.cell_out, rsp_if.setpoint);
                fail_count++;
            end else begin
                want = status_due_q.pop_front();
                check_field("cell_out", int'(want.cell_idx), int'(rsp_if.cell_out));
                check_field("setpoint", int'(want.cmd), int'(rsp_if.setpoint));
                check_field("run_state", int'(want.run), int'(rsp_if.run_state));
                check_field("prog_phase", int'(want.phase), int'(rsp_if.prog_phase));
                check_field("error_code", int'(want.fault), int'(rsp_if.error_code));
                check_field("start_refused", int'(want.refused), int'(rsp_if.start_refused));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

endmodule
